>>> design/assert_macros.svh
// Assertion macros for the top-level design file.
// Each macro takes a label, the clock, the active-low reset, a condition and
// the property that must follow from it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/lph_pkg.sv
`timescale 1ns / 1ps

package lph_pkg;

    // Table geometry and field widths.
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = IDX_W + 1;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int KEY_CNT_W   = $clog2(KEY_BITS);

    // Request kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_INSERTED  = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_FOUND     = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_code_t;

    // One row of the slot memory.
    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } slot_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic         clear_en;
        logic         load_op;
        logic         div_step;
        logic         slot_init;
        logic         mem_read;
        logic         advance;
        logic         write_en;
        logic         out_load;
        status_code_t out_status;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic div_last;
        logic rd_valid;
        logic key_match;
        logic sweep_last;
        logic op_kind;
        logic out_free;
    } dp_status_t;

endpackage

>>> design/lph_channels.sv
`timescale 1ns / 1ps

// Request channel: one insert or lookup per transfer.
interface lph_req_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [lph_pkg::KEY_BITS-1:0]   key;
    logic [lph_pkg::VALUE_BITS-1:0] value_in;

    modport source (output valid, output kind, output key, output value_in, input ready);
    modport sink (input valid, input kind, input key, input value_in, output ready);
endinterface

// Response channel: one result per request.
interface lph_resp_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [lph_pkg::VALUE_BITS-1:0] value_out;

    modport source (output valid, output status, output value_out, input ready);
    modport sink (input valid, input status, input value_out, output ready);
endinterface

>>> design/linear_probe_hash_table_unit.sv
// A request runs from acceptance through the divide and the probes of the slots to its response.
// The key modulo table size comes from a bit-serial divider, one key bit a cycle.
// Each probe is one read of the slot memory, in S_READ, and one compare, in S_CHECK.
// One request at a time: the next is accepted only after the response of the last is loaded.
// Reset: a clearing pass zeroes every slot; requests wait until it ends.
// Table size resets to 1024; configuration writes are taken at any time.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linear_probe_hash_table_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [lph_pkg::SIZE_W-1:0] cfg_wr_data,
    lph_req_if.sink                    req,
    lph_resp_if.source                 resp
);

    lph_pkg::dp_cmd_t    cmd;
    lph_pkg::dp_status_t stat;
    logic                req_ready;
    logic                req_fire;

    assign req.ready = req_ready;
    assign req_fire  = req.valid && req_ready;

    // Sequencer for clear, divide, probe and respond.
    lph_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Divider, slot memory, probe counters and response register.
    lph_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_kind    (req.kind),
        .req_key     (req.key),
        .req_value   (req.value_in),
        .resp_valid  (resp.valid),
        .resp_ready  (resp.ready),
        .resp_status (resp.status),
        .resp_value  (resp.value_out),
        .cmd         (cmd),
        .stat        (stat)
    );

    // Only one request is in flight at a time.
    `ASSERT_NEXT(a_single_request, clk, rst_n, req_fire, !req_ready)
    // A new response never overwrites one that has not been taken.
    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, cmd.out_load, !resp.valid || resp.ready)
    // Besides the clearing pass, slots are written only by an insert that found an empty slot.
    `ASSERT_IMPLIES(a_insert_write, clk, rst_n, cmd.write_en,
        stat.op_kind == lph_pkg::KIND_INSERT && !stat.rd_valid)
    // No request is taken while the clearing pass runs.
    `ASSERT_IMPLIES(a_no_req_in_clear, clk, rst_n, cmd.clear_en, !req_ready)

endmodule

>>> design/lph_ctrl.sv
`timescale 1ns / 1ps

module lph_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lph_pkg::dp_status_t stat,
    output lph_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    lph_pkg::status_code_t code_reg;
    lph_pkg::status_code_t code_next;

    // Next-state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        req_ready      = 1'b0;
        cmd            = '0;
        cmd.out_status = code_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_op = 1'b1;
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    cmd.slot_init = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                if (!stat.rd_valid)
                begin
                    // Empty slot ends both kinds of probe.
                    if (stat.op_kind == lph_pkg::KIND_INSERT)
                    begin
                        cmd.write_en = 1'b1;
                        code_next    = lph_pkg::STATUS_INSERTED;
                    end
                    else
                    begin
                        code_next = lph_pkg::STATUS_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
                else if (stat.op_kind == lph_pkg::KIND_LOOKUP && stat.key_match)
                begin
                    code_next  = lph_pkg::STATUS_FOUND;
                    state_next = S_DONE;
                end
                else if (stat.sweep_last)
                begin
                    code_next  = (stat.op_kind == lph_pkg::KIND_INSERT) ?
                                 lph_pkg::STATUS_FULL : lph_pkg::STATUS_NOT_FOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result code registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            code_reg  <= lph_pkg::STATUS_INSERTED;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

>>> design/lph_datapath.sv
`timescale 1ns / 1ps

module lph_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lph_pkg::SIZE_W-1:0]     cfg_wr_data,
    input  logic                           req_kind,
    input  logic [lph_pkg::KEY_BITS-1:0]   req_key,
    input  logic [lph_pkg::VALUE_BITS-1:0] req_value,
    output logic                           resp_valid,
    input  logic                           resp_ready,
    output logic [1:0]                     resp_status,
    output logic [lph_pkg::VALUE_BITS-1:0] resp_value,
    input  lph_pkg::dp_cmd_t               cmd,
    output lph_pkg::dp_status_t            stat
);

    // Control registers.
    logic [lph_pkg::SIZE_W-1:0]     cfg_size_reg;
    logic [lph_pkg::IDX_W-1:0]      clr_idx_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    // Operand and probe registers.
    logic                           kind_reg;
    logic [lph_pkg::KEY_BITS-1:0]   key_reg;
    logic [lph_pkg::VALUE_BITS-1:0] value_reg;
    logic [lph_pkg::SIZE_W-1:0]     size_reg;
    logic [lph_pkg::KEY_BITS-1:0]   div_key_reg;
    logic [lph_pkg::SIZE_W-1:0]     rem_reg;
    logic [lph_pkg::KEY_CNT_W-1:0]  div_cnt_reg;
    logic [lph_pkg::IDX_W-1:0]      slot_reg;
    logic [lph_pkg::SIZE_W-1:0]     probe_cnt_reg;
    lph_pkg::slot_entry_t           rd_reg;
    logic [1:0]                     out_status_reg;
    logic [lph_pkg::VALUE_BITS-1:0] out_value_reg;

    // Slot memory.
    lph_pkg::slot_entry_t           mem [lph_pkg::TABLE_DEPTH];

    logic [lph_pkg::SIZE_W-1:0]     eff_size;
    logic [lph_pkg::SIZE_W:0]       div_trial;
    logic [lph_pkg::SIZE_W-1:0]     rem_step;
    logic [lph_pkg::SIZE_W-1:0]     probe_inc;
    logic [lph_pkg::SIZE_W-1:0]     slot_inc;
    logic [lph_pkg::IDX_W-1:0]      slot_wrap;
    logic                           mem_we;
    logic [lph_pkg::IDX_W-1:0]      mem_waddr;
    lph_pkg::slot_entry_t           mem_wdata;

    // Clamp the configured size to 1..TABLE_DEPTH.
    always_comb
    begin
        if (cfg_size_reg == '0)
        begin
            eff_size = lph_pkg::SIZE_W'(1);
        end
        else if (cfg_size_reg > lph_pkg::SIZE_W'(lph_pkg::TABLE_DEPTH))
        begin
            eff_size = lph_pkg::SIZE_W'(lph_pkg::TABLE_DEPTH);
        end
        else
        begin
            eff_size = cfg_size_reg;
        end
    end

    // One restoring division step per cycle: remainder of key by size.
    always_comb
    begin
        div_trial = {rem_reg, div_key_reg[lph_pkg::KEY_BITS-1]};
        if (div_trial >= {1'b0, size_reg})
        begin
            rem_step = lph_pkg::SIZE_W'(div_trial - {1'b0, size_reg});
        end
        else
        begin
            rem_step = lph_pkg::SIZE_W'(div_trial);
        end
    end

    // Probe counter and slot wraparound.
    assign probe_inc = probe_cnt_reg + lph_pkg::SIZE_W'(1);
    assign slot_inc  = {1'b0, slot_reg} + lph_pkg::SIZE_W'(1);
    assign slot_wrap = (slot_inc == size_reg) ? '0 : slot_inc[lph_pkg::IDX_W-1:0];

    // Memory write port: clearing pass or insert.
    always_comb
    begin
        mem_we    = cmd.clear_en | cmd.write_en;
        mem_waddr = cmd.clear_en ? clr_idx_reg : slot_reg;
        mem_wdata = '0;
        if (!cmd.clear_en)
        begin
            mem_wdata.valid = 1'b1;
            mem_wdata.key   = key_reg;
            mem_wdata.value = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
        begin
            rd_reg <= mem[slot_reg];
        end
    end

    // Output handshake state.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (resp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_size_reg  <= lph_pkg::SIZE_W'(lph_pkg::TABLE_DEPTH);
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_size_reg <= cfg_wr_data;
            end
            if (cmd.clear_en)
            begin
                clr_idx_reg <= clr_idx_reg + lph_pkg::IDX_W'(1);
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Operand, divider, probe and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            kind_reg    <= req_kind;
            key_reg     <= req_key;
            value_reg   <= req_value;
            size_reg    <= eff_size;
            div_key_reg <= req_key;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            div_key_reg <= {div_key_reg[lph_pkg::KEY_BITS-2:0], 1'b0};
            rem_reg     <= rem_step;
            div_cnt_reg <= div_cnt_reg + lph_pkg::KEY_CNT_W'(1);
        end
        if (cmd.slot_init)
        begin
            slot_reg      <= rem_step[lph_pkg::IDX_W-1:0];
            probe_cnt_reg <= '0;
        end
        if (cmd.advance)
        begin
            slot_reg      <= slot_wrap;
            probe_cnt_reg <= probe_inc;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_value_reg  <= (cmd.out_status == lph_pkg::STATUS_FOUND) ? rd_reg.value : '0;
        end
    end

    // Status back to the controller.
    always_comb
    begin
        stat.clear_last = (clr_idx_reg == lph_pkg::IDX_W'(lph_pkg::TABLE_DEPTH - 1));
        stat.div_last   = (div_cnt_reg == lph_pkg::KEY_CNT_W'(lph_pkg::KEY_BITS - 1));
        stat.rd_valid   = rd_reg.valid;
        stat.key_match  = (rd_reg.key == key_reg);
        stat.sweep_last = (probe_inc == size_reg);
        stat.op_kind    = kind_reg;
        stat.out_free   = !out_valid_reg || resp_ready;
    end

    assign resp_valid  = out_valid_reg;
    assign resp_status = out_status_reg;
    assign resp_value  = out_value_reg;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lph_pkg::*;

    // Cycles with no request or response transfer before the run is abandoned.
    // The slowest request is a full sweep of 1024 slots.
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int DRAIN_CYCLES    = 50;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_REQUESTS  = 40;
    localparam int MAX_REPORTED    = 50;

    typedef struct {
        status_code_t          status;
        logic [VALUE_BITS-1:0] value;
    } probe_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [SIZE_W-1:0] cfg_wr_data;

    lph_req_if  req_ch ();
    lph_resp_if resp_ch ();

    linear_probe_hash_table_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .resp        (resp_ch)
    );

    // Shadow copy of the slot memory and the size register.
    bit                    shadow_used [TABLE_DEPTH];
    logic [KEY_BITS-1:0]   shadow_key [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] shadow_value [TABLE_DEPTH];
    logic [SIZE_W-1:0]     shadow_size = SIZE_W'(TABLE_DEPTH);
    int                    slots_filled = 0;
    logic [KEY_BITS-1:0]   stored_keys [$];

    probe_result_t pending_results [$];
    int            error_count = 0;
    int            idle_cycles = 0;
    bit            no_gaps = 1'b0;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sizes of zero and above the depth are clamped by the block.
    function automatic int effective_size();
        if (shadow_size == 0)
            return 1;
        if (shadow_size > TABLE_DEPTH)
            return TABLE_DEPTH;
        return int'(shadow_size);
    endfunction

    // Walk the shadow table the way the block probes it and update it on insert.
    function automatic probe_result_t probe_table(input logic kind,
                                                  input logic [KEY_BITS-1:0] key,
                                                  input logic [VALUE_BITS-1:0] value);
        probe_result_t res;
        int            span;
        int            slot;
        int            n;
        span = effective_size();
        slot = int'(key % 32'(span));
        res.status = (kind == KIND_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
        res.value = '0;
        for (n = 0; n < span; n++)
        begin
            if (!shadow_used[slot])
            begin
                if (kind == KIND_INSERT)
                begin
                    shadow_used[slot] = 1'b1;
                    shadow_key[slot] = key;
                    shadow_value[slot] = value;
                    slots_filled++;
                    stored_keys.push_back(key);
                    res.status = STATUS_INSERTED;
                end
                break;
            end
            if (kind == KIND_LOOKUP && shadow_key[slot] == key)
            begin
                res.status = STATUS_FOUND;
                res.value = shadow_value[slot];
                break;
            end
            slot = (slot + 1 == span) ? 0 : slot + 1;
        end
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Keys already stored, fully random keys, and small keys that crowd the low slots.
    function automatic logic [KEY_BITS-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 && stored_keys.size() > 0)
            return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        if (r < 7)
            return $urandom();
        return $urandom_range(0, 4 * effective_size());
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_REPORTED)
            $display("[%0t] mismatch: %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
        error_count++;
    endtask

    // Drive one request after a random gap, none when no_gaps is set, and record its expected response once accepted.
    task automatic send_request(input logic kind, input logic [KEY_BITS-1:0] key,
                                input logic [VALUE_BITS-1:0] value);
        int gap;
        gap = no_gaps ? 0 : idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.kind = kind;
        req_ch.key = key;
        req_ch.value_in = value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(probe_table(kind, key, value));
    endtask

    // Stop requesting and wait until every response is back.
    task automatic wait_for_idle();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_table_size(input logic [SIZE_W-1:0] size);
        wait_for_idle();
        cfg_wr_en = 1'b1;
        cfg_wr_data = size;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        shadow_size = size;
    endtask

    // Empty table, extreme keys and values, wrap at the top slot and duplicate inserts.
    task automatic test_empty_wrap_duplicates();
        send_request(KIND_LOOKUP, 32'h0000_0000, $urandom());
        send_request(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'd1023, 32'h0000_0000);
        send_request(KIND_LOOKUP, 32'd1023, 32'hFFFF_FFFF);
        send_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(KIND_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
        send_request(KIND_INSERT, 32'd1023, 32'h5A5A_5A5A);
        send_request(KIND_LOOKUP, 32'd1023, $urandom());
        send_request(KIND_LOOKUP, 32'd1024, $urandom());
        wait_for_idle();
    endtask

    // Clamped sizes, a full table, lookup sweeps and slots hidden beyond the size.
    task automatic test_size_limits();
        write_table_size(SIZE_W'(0));
        send_request(KIND_INSERT, 32'h0001_2345, $urandom());
        send_request(KIND_LOOKUP, 32'd1023, $urandom());
        send_request(KIND_LOOKUP, 32'd7, $urandom());
        write_table_size(SIZE_W'(1));
        send_request(KIND_LOOKUP, 32'h0000_0000, $urandom());
        write_table_size(SIZE_W'(2047));
        send_request(KIND_LOOKUP, 32'h0000_0000, $urandom());
        write_table_size(SIZE_W'(3));
        send_request(KIND_INSERT, $urandom(), $urandom());
        send_request(KIND_LOOKUP, 32'hFFFF_FFFF, $urandom());
        write_table_size(SIZE_W'(1025));
        send_request(KIND_LOOKUP, 32'hFFFF_FFFF, $urandom());
        write_table_size(SIZE_W'(TABLE_DEPTH));
    endtask

    // Phases of mixed requests, each under a new random size; the range of the larger sizes grows over the run.
    task automatic test_random_phases();
        int ph;
        int n;
        int r;
        logic [SIZE_W-1:0] size;
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                size = '0;
            else if (r == 1)
                size = SIZE_W'(1);
            else if (r == 2)
                size = SIZE_W'($urandom_range(TABLE_DEPTH + 1, 2047));
            else if (r < 6)
                size = SIZE_W'($urandom_range(2, 16));
            else
                size = SIZE_W'($urandom_range(17, 40 + 40 * ph));
            write_table_size(size);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (n = 0; n < PHASE_REQUESTS; n++)
                send_request($urandom_range(0, 1) ? KIND_LOOKUP : KIND_INSERT, pick_key(),
                             $urandom());
        end
        no_gaps = 1'b0;
        wait_for_idle();
    endtask

    // Fill the whole table at full size, then insert into it and sweep it.
    task automatic test_fill_max_size();
        int n;
        write_table_size(SIZE_W'(TABLE_DEPTH));
        while (slots_filled < TABLE_DEPTH)
            send_request(($urandom_range(0, 4) == 0) ? KIND_LOOKUP : KIND_INSERT, pick_key(),
                         $urandom());
        for (n = 0; n < 3; n++)
        begin
            send_request(KIND_INSERT, $urandom(), $urandom());
            send_request(KIND_LOOKUP, $urandom(), $urandom());
            send_request(KIND_LOOKUP, pick_key(), $urandom());
        end
        wait_for_idle();
    endtask

    // Main sequence: reset, the tests in turn, then drain and report.
    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_INSERT;
        req_ch.key = '0;
        req_ch.value_in = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_wrap_duplicates();
        test_size_limits();
        test_random_phases();
        test_fill_max_size();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("** linear_probe_hash_table_unit: PASSED **");
        else
            $display("** linear_probe_hash_table_unit: FAILED **");
        $finish;
    end

    // Response ready: runs of readiness, some long, broken by stalls of random length.
    initial
    begin : resp_pacing
        int run;
        resp_ch.ready = 1'b0;
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
            @(negedge clk);
            resp_ch.ready = 1'b1;
            repeat (run) @(negedge clk);
            run = idle_gap();
            if (run > 0)
            begin
                resp_ch.ready = 1'b0;
                repeat (run - 1) @(negedge clk);
            end
        end
    end

    // Compare each response with the oldest outstanding expectation.
    always @(posedge clk)
    begin : check_responses
        probe_result_t want;
        if (rst_n && resp_ch.valid && resp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("response with no request outstanding",
                                32'(resp_ch.status), 32'h0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (resp_ch.status !== want.status)
                    report_mismatch({"status, expected ", want.status.name()},
                                    32'(resp_ch.status), 32'(want.status));
                if (resp_ch.value_out !== want.value)
                    report_mismatch("value_out", resp_ch.value_out, want.value);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves anything.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] timeout with %0d responses outstanding", $time,
                     pending_results.size());
            $display("** linear_probe_hash_table_unit: FAILED **");
            $finish;
        end
    end

endmodule
